### sv/utf8vd_pkg.sv
// Package for the UTF-8 validating decoder: byte classes, status codes,
// the queue entry type and the byte range limits.
// No dependencies; every RTL file of the decoder uses it.
`default_nettype none
package utf8vd_pkg;

	localparam int unsigned QUEUE_DEPTH = 2;

	localparam int unsigned CP_W = 21;

	localparam logic [7:0] ASCII_MAX = 8'h7F;
	localparam logic [7:0] CONT_MAX  = 8'hBF;
	localparam logic [7:0] LEAD2_MAX = 8'hDF;
	localparam logic [7:0] LEAD3_MAX = 8'hEF;
	localparam logic [7:0] LEAD4_MAX = 8'hF7;

	localparam logic [7:0] CONT_MASK  = 8'h3F;
	localparam logic [7:0] LEAD2_MASK = 8'h1F;
	localparam logic [7:0] LEAD3_MASK = 8'h0F;
	localparam logic [7:0] LEAD4_MASK = 8'h07;

	localparam logic [CP_W-1:0] SURR_LO = 21'h00D800;
	localparam logic [CP_W-1:0] SURR_HI = 21'h00DFFF;
	localparam logic [CP_W-1:0] CP_MAX  = 21'h10FFFF;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_STRAY   = 3'd1,
		ST_BADLEAD = 3'd2,
		ST_TRUNC   = 3'd3,
		ST_BADCONT = 3'd4,
		ST_SURR    = 3'd5,
		ST_LARGE   = 3'd6
	} status_t;

	typedef enum logic [2:0] {
		CLS_ASCII   = 3'd0,
		CLS_CONT    = 3'd1,
		CLS_LEAD2   = 3'd2,
		CLS_LEAD3   = 3'd3,
		CLS_LEAD4   = 3'd4,
		CLS_BADLEAD = 3'd5
	} byte_class_t;

	// Classified byte: class, payload bits already masked, end-of-string mark.
	typedef struct packed {
		byte_class_t cls;
		logic [6:0]  bits;
		logic        eos;
	} item_t;

	// Queue read side as seen by the back end.
	typedef struct packed {
		logic  valid;
		item_t item;
	} queue_head_t;

endpackage
`default_nettype wire

### sv/utf8vd_front.sv
// Front end of the UTF-8 decoder: classifies each incoming byte and
// stores it in a short queue for the back end. Depends on utf8vd_pkg.
`default_nettype none
module utf8vd_front #(
	parameter int unsigned QueueDepth = utf8vd_pkg::QUEUE_DEPTH
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    push,
	output logic                         full,
	input  wire logic [7:0]              byte_value,
	input  wire logic                    end_of_string,
	input  wire logic                    take,
	output utf8vd_pkg::queue_head_t      head
);

	localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
	localparam int unsigned CntW = $clog2(QueueDepth + 1);
	localparam logic [PtrW-1:0] PtrLast = PtrW'(QueueDepth - 1);
	localparam logic [CntW-1:0] CntFull = CntW'(QueueDepth);

	utf8vd_pkg::item_t entries_q [QueueDepth];
	logic [PtrW-1:0]   wr_ptr_q;
	logic [PtrW-1:0]   rd_ptr_q;
	logic [CntW-1:0]   count_q;

	utf8vd_pkg::item_t new_item;
	logic              wr_en;
	logic              rd_en;

	always_comb begin
		new_item.eos = end_of_string;
		priority if (byte_value <= utf8vd_pkg::ASCII_MAX) begin
			new_item.cls  = utf8vd_pkg::CLS_ASCII;
			new_item.bits = byte_value[6:0];
		end else if (byte_value <= utf8vd_pkg::CONT_MAX) begin
			new_item.cls  = utf8vd_pkg::CLS_CONT;
			new_item.bits = 7'(byte_value & utf8vd_pkg::CONT_MASK);
		end else if (byte_value <= utf8vd_pkg::LEAD2_MAX) begin
			new_item.cls  = utf8vd_pkg::CLS_LEAD2;
			new_item.bits = 7'(byte_value & utf8vd_pkg::LEAD2_MASK);
		end else if (byte_value <= utf8vd_pkg::LEAD3_MAX) begin
			new_item.cls  = utf8vd_pkg::CLS_LEAD3;
			new_item.bits = 7'(byte_value & utf8vd_pkg::LEAD3_MASK);
		end else if (byte_value <= utf8vd_pkg::LEAD4_MAX) begin
			new_item.cls  = utf8vd_pkg::CLS_LEAD4;
			new_item.bits = 7'(byte_value & utf8vd_pkg::LEAD4_MASK);
		end else begin
			new_item.cls  = utf8vd_pkg::CLS_BADLEAD;
			new_item.bits = '0;
		end
	end

	assign full       = (count_q == CntFull);
	assign wr_en      = push && !full;
	assign rd_en      = take && (count_q != '0);
	assign head.valid = (count_q != '0);
	assign head.item  = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entries_q[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntFull)
		else $error("queue count exceeds depth");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && !rd_en) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count did not advance on a lone write");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers disagree while empty");
`endif

endmodule
`default_nettype wire

### sv/utf8vd_back.sv
// Back end of the UTF-8 decoder: sequence state, accumulator, fault
// handling and the result register. Depends on utf8vd_pkg.
`default_nettype none
module utf8vd_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire utf8vd_pkg::queue_head_t     head,
	output logic                             take,
	output logic                             empty,
	input  wire logic                        pop,
	output logic [utf8vd_pkg::CP_W-1:0]      code_point,
	output logic [2:0]                       status,
	output logic                             string_done
);

	localparam int unsigned CpW = utf8vd_pkg::CP_W;

	logic [1:0]     pending_q;
	logic [CpW-1:0] accum_q;
	logic           discarding_q;

	logic               out_valid_q;
	logic [CpW-1:0]     out_cp_q;
	utf8vd_pkg::status_t out_st_q;
	logic               out_done_q;

	logic [1:0]          nxt_pending;
	logic [CpW-1:0]      nxt_accum;
	logic                nxt_discarding;
	logic                res_valid;
	logic [CpW-1:0]      res_cp;
	utf8vd_pkg::status_t res_st;
	logic                res_done;
	logic                fault;
	utf8vd_pkg::status_t fault_code;
	logic [CpW-1:0]      shifted;
	logic [1:0]          dec_pending;
	utf8vd_pkg::item_t   it;

	assign it      = head.item;
	// Advance when the queue head is valid and the result slot is free or being drained this cycle.
	assign take    = head.valid && (!out_valid_q || pop);
	assign shifted = {accum_q[CpW-7:0], it.bits[5:0]};
	assign dec_pending = pending_q - 2'd1;

	always_comb begin
		nxt_pending    = pending_q;
		nxt_accum      = accum_q;
		nxt_discarding = discarding_q;
		res_valid      = 1'b0;
		res_cp         = '0;
		res_st         = utf8vd_pkg::ST_OK;
		res_done       = 1'b0;
		fault          = 1'b0;
		fault_code     = utf8vd_pkg::ST_OK;

		if (discarding_q) begin
			// Drop silently; end of string clears everything.
			if (it.eos) begin
				nxt_pending    = '0;
				nxt_accum      = '0;
				nxt_discarding = 1'b0;
			end
		end else if (pending_q == 2'd0) begin
			unique case (it.cls)
				utf8vd_pkg::CLS_ASCII: begin
					res_valid = 1'b1;
					res_cp    = CpW'(it.bits);
					res_done  = it.eos;
					nxt_accum = '0;
				end
				utf8vd_pkg::CLS_CONT: begin
					fault      = 1'b1;
					fault_code = utf8vd_pkg::ST_STRAY;
				end
				utf8vd_pkg::CLS_LEAD2, utf8vd_pkg::CLS_LEAD3,
				utf8vd_pkg::CLS_LEAD4: begin
					if (it.eos) begin
						fault      = 1'b1;
						fault_code = utf8vd_pkg::ST_TRUNC;
					end else begin
						nxt_accum = CpW'(it.bits);
						unique case (it.cls)
							utf8vd_pkg::CLS_LEAD2: nxt_pending = 2'd1;
							utf8vd_pkg::CLS_LEAD3: nxt_pending = 2'd2;
							default:               nxt_pending = 2'd3;
						endcase
					end
				end
				default: begin
					fault      = 1'b1;
					fault_code = utf8vd_pkg::ST_BADLEAD;
				end
			endcase
		end else if (it.cls != utf8vd_pkg::CLS_CONT) begin
			fault      = 1'b1;
			fault_code = utf8vd_pkg::ST_BADCONT;
		end else if (dec_pending == 2'd0) begin
			priority if (shifted >= utf8vd_pkg::SURR_LO && shifted <= utf8vd_pkg::SURR_HI) begin
				fault      = 1'b1;
				fault_code = utf8vd_pkg::ST_SURR;
			end else if (shifted > utf8vd_pkg::CP_MAX) begin
				fault      = 1'b1;
				fault_code = utf8vd_pkg::ST_LARGE;
			end else begin
				res_valid   = 1'b1;
				res_cp      = shifted;
				res_done    = it.eos;
				nxt_pending = '0;
				nxt_accum   = '0;
			end
		end else if (it.eos) begin
			fault      = 1'b1;
			fault_code = utf8vd_pkg::ST_TRUNC;
		end else begin
			nxt_accum   = shifted;
			nxt_pending = dec_pending;
		end

		if (fault) begin
			res_valid      = 1'b1;
			res_cp         = '0;
			res_st         = fault_code;
			res_done       = 1'b1;
			nxt_pending    = '0;
			nxt_accum      = '0;
			nxt_discarding = !it.eos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q    <= '0;
			accum_q      <= '0;
			discarding_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (take) begin
				pending_q    <= nxt_pending;
				accum_q      <= nxt_accum;
				discarding_q <= nxt_discarding;
				out_valid_q  <= res_valid;
			end else if (pop) begin
				out_valid_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && res_valid) begin
			out_cp_q   <= res_cp;
			out_st_q   <= res_st;
			out_done_q <= res_done;
		end
	end

	assign empty       = !out_valid_q;
	assign code_point  = out_cp_q;
	assign status      = out_st_q;
	assign string_done = out_done_q;

`ifndef ASSERT_OFF
	a_fault_zero_cp: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_st_q != utf8vd_pkg::ST_OK) |-> (out_cp_q == '0))
		else $error("fault result carries a nonzero code point");

	a_fault_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_st_q != utf8vd_pkg::ST_OK) |-> out_done_q)
		else $error("fault result does not end the string");

	a_discard_idle: assert property (@(posedge clk) disable iff (!arst_n)
		discarding_q |-> (pending_q == 2'd0 && accum_q == '0))
		else $error("sequence state left over while discarding");

	a_ok_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_st_q == utf8vd_pkg::ST_OK) |-> (out_cp_q <= utf8vd_pkg::CP_MAX))
		else $error("accepted code point above the scalar range");
`endif

endmodule
`default_nettype wire

### sv/utf8_validating_decoder_top.sv
// Top level of the UTF-8 validating decoder: front classifier with queue,
// back-end sequence decoder with result register. Depends on utf8vd_pkg,
// utf8vd_front and utf8vd_back.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------------
//   input   | in        | push / full          | byte_value[7:0], end_of_string
//   result  | out       | empty / pop          | code_point[20:0], status[2:0], string_done
//
// One byte per cycle sustained on both sides while results are popped. A byte is
// first written into the queue; the decoder then reads it at the queue head,
// updates the accumulator and loads the result register with its result (if any).
// Asynchronous reset clears the queue, sequence state and result valid.
// A stalled result holds the decoder; the queue then absorbs QueueDepth bytes
// before full rises.
`default_nettype none
module utf8_validating_decoder_top #(
	parameter int unsigned QueueDepth = utf8vd_pkg::QUEUE_DEPTH
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       push,
	output logic                            full,
	input  wire logic [7:0]                 byte_value,
	input  wire logic                       end_of_string,
	output logic                            empty,
	input  wire logic                       pop,
	output logic [utf8vd_pkg::CP_W-1:0]     code_point,
	output logic [2:0]                      status,
	output logic                            string_done
);

	utf8vd_pkg::queue_head_t head;
	logic                    take;

	utf8vd_front #(
		.QueueDepth(QueueDepth)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.byte_value   (byte_value),
		.end_of_string(end_of_string),
		.take         (take),
		.head         (head)
	);

	utf8vd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.take       (take),
		.empty      (empty),
		.pop        (pop),
		.code_point (code_point),
		.status     (status),
		.string_done(string_done)
	);

endmodule
`default_nettype wire

### bench/utf8_validating_decoder_top_test.sv
`timescale 1ns / 100ps
// Self-checking bench for utf8_validating_decoder_top: byte strings in, code points out,
// compared against a code point tracker class. Depends on utf8vd_pkg and the decoder RTL.
module utf8_validating_decoder_top_test;

	localparam int unsigned CpW = utf8vd_pkg::CP_W;
	localparam int unsigned CYCLE_LIMIT = 200_000;
	localparam int unsigned RANDOM_BYTES = 1700;

	// {end_of_string, byte_value}
	localparam logic [8:0] DIRECTED [29] = '{
		9'h000, 9'h17F,                         // ASCII extremes
		9'h0C2, 9'h0A9, 9'h0E2, 9'h082, 9'h1AC, // two- and three-byte values
		9'h0F4, 9'h08F, 9'h0BF, 9'h1BF,         // largest scalar value
		9'h0ED, 9'h0A0, 9'h180,                 // surrogate on the final byte
		9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF, 9'h1FF, // too large mid-string, tail dropped
		9'h180,                                 // stray continuation
		9'h0F8, 9'h1C3,                         // bad lead, tail dropped
		9'h1E2,                                 // lead carries the end mark
		9'h0C3, 9'h041, 9'h141,                 // bad continuation
		9'h0E2, 9'h182,                         // continuation carries the end mark
		9'h1FF                                  // bad lead on the final byte
	};

	typedef struct packed {
		logic [CpW-1:0]      cp;
		utf8vd_pkg::status_t st;
		logic                done;
	} decoded_t;

	class code_point_tracker;
		logic [1:0]     cont_left;
		logic [CpW-1:0] partial_cp;
		bit             dropping;
		decoded_t       decoded_queue[$];
		int unsigned    mismatches;

		function void clear_state();
			cont_left = '0;
			partial_cp = '0;
			dropping = 1'b0;
		endfunction

		function void push_fault(utf8vd_pkg::status_t st, logic eos);
			decoded_queue.push_back('{cp: '0, st: st, done: 1'b1});
			clear_state();
			if (!eos)
				dropping = 1'b1;
		endfunction

		function void push_value(logic [CpW-1:0] cp, logic eos);
			decoded_queue.push_back('{cp: cp, st: utf8vd_pkg::ST_OK, done: eos});
			cont_left = '0;
			partial_cp = '0;
		endfunction

		// Returns 1 when the byte is swallowed while skipping to the end of a string.
		function bit take_byte(logic [7:0] b, logic eos);
			if (dropping) begin
				if (eos)
					clear_state();
				return 1'b1;
			end
			if (cont_left == 0) begin
				if (b <= utf8vd_pkg::ASCII_MAX) begin
					push_value(CpW'(b), eos);
				end else if (b <= utf8vd_pkg::CONT_MAX) begin
					push_fault(utf8vd_pkg::ST_STRAY, eos);
				end else if (b <= utf8vd_pkg::LEAD4_MAX) begin
					if (b <= utf8vd_pkg::LEAD2_MAX) begin
						partial_cp = CpW'(b & utf8vd_pkg::LEAD2_MASK);
						cont_left = 2'd1;
					end else if (b <= utf8vd_pkg::LEAD3_MAX) begin
						partial_cp = CpW'(b & utf8vd_pkg::LEAD3_MASK);
						cont_left = 2'd2;
					end else begin
						partial_cp = CpW'(b & utf8vd_pkg::LEAD4_MASK);
						cont_left = 2'd3;
					end
					if (eos)
						push_fault(utf8vd_pkg::ST_TRUNC, eos);
				end else begin
					push_fault(utf8vd_pkg::ST_BADLEAD, eos);
				end
			end else if (b <= utf8vd_pkg::ASCII_MAX || b > utf8vd_pkg::CONT_MAX) begin
				push_fault(utf8vd_pkg::ST_BADCONT, eos);
			end else begin
				partial_cp = {partial_cp[CpW-7:0], b[5:0]};
				cont_left = cont_left - 2'd1;
				if (cont_left == 0) begin
					// surrogate range wins over the upper bound
					if (partial_cp >= utf8vd_pkg::SURR_LO && partial_cp <= utf8vd_pkg::SURR_HI)
						push_fault(utf8vd_pkg::ST_SURR, eos);
					else if (partial_cp > utf8vd_pkg::CP_MAX)
						push_fault(utf8vd_pkg::ST_LARGE, eos);
					else
						push_value(partial_cp, eos);
				end else if (eos) begin
					push_fault(utf8vd_pkg::ST_TRUNC, eos);
				end
			end
			return 1'b0;
		endfunction

		function void compare_result(logic [CpW-1:0] cp, logic [2:0] st, logic done);
			decoded_t exp;
			if (decoded_queue.size() == 0) begin
				$display("%0t: expected no result, actual code_point %h status %0d string_done %b",
					$time, cp, st, done);
				mismatches++;
				return;
			end
			exp = decoded_queue.pop_front();
			if (cp !== exp.cp) begin
				$display("%0t: code_point expected %h actual %h", $time, exp.cp, cp);
				mismatches++;
			end
			if (st !== exp.st) begin
				$display("%0t: status expected %0d (%s) actual %0d",
					$time, exp.st, exp.st.name(), st);
				mismatches++;
			end
			if (done !== exp.done) begin
				$display("%0t: string_done expected %b actual %b", $time, exp.done, done);
				mismatches++;
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              push = 1'b0;
	logic              full;
	logic [7:0]        byte_value = '0;
	logic              end_of_string = 1'b0;
	logic              empty;
	logic              pop = 1'b0;
	logic [CpW-1:0]    code_point;
	logic [2:0]        status;
	logic              string_done;

	int unsigned       send_idle_pct = 0;
	int unsigned       recv_stall_pct = 0;
	int unsigned       counted_bytes = 0;
	int unsigned       cycle_count = 0;
	code_point_tracker tracker = new();

	utf8_validating_decoder_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.byte_value    (byte_value),
		.end_of_string (end_of_string),
		.empty         (empty),
		.pop           (pop),
		.code_point    (code_point),
		.status        (status),
		.string_done   (string_done)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		pop <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Watch both channels; a byte's result cannot show up at the edge of its own transfer.
	always @(posedge clk) begin
		if (arst_n && push && !full) begin
			if (!tracker.take_byte(byte_value, end_of_string))
				counted_bytes <= counted_bytes + 1;
		end
		if (arst_n && pop && !empty)
			tracker.compare_result(code_point, status, string_done);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Call and return at a rising edge; returns at the edge of the transfer.
	task automatic send_byte(input logic [7:0] b, input logic eos);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		byte_value <= b;
		end_of_string <= eos;
		@(posedge clk);
		while (full)
			@(posedge clk);
	endtask

	// Mostly well-formed strings with random content; some corrupted, cut short, or pure noise.
	task automatic send_random_string();
		logic [7:0] bytes[$];
		int         kind;
		int         len;
		int         pos;
		kind = $urandom_range(99);
		if (kind < 10) begin
			repeat ($urandom_range(1, 8))
				send_byte(8'($urandom), $urandom_range(7) == 0);
			send_byte(8'($urandom), 1'b1);
			return;
		end
		repeat ($urandom_range(1, 6)) begin
			len = $urandom_range(1, 4);
			case (len)
				1: begin
					bytes.push_back(8'($urandom_range(0, utf8vd_pkg::ASCII_MAX)));
				end
				2: begin
					bytes.push_back(8'($urandom_range(utf8vd_pkg::CONT_MAX + 1,
						utf8vd_pkg::LEAD2_MAX)));
				end
				3: begin
					bytes.push_back(8'($urandom_range(utf8vd_pkg::LEAD2_MAX + 1,
						utf8vd_pkg::LEAD3_MAX)));
				end
				default: begin
					bytes.push_back(8'($urandom_range(utf8vd_pkg::LEAD3_MAX + 1,
						utf8vd_pkg::LEAD4_MAX)));
				end
			endcase
			repeat (len - 1)
				bytes.push_back(8'($urandom_range(utf8vd_pkg::ASCII_MAX + 1,
					utf8vd_pkg::CONT_MAX)));
		end
		if (kind < 22) begin
			pos = $urandom_range(bytes.size() - 1);
			bytes[pos] = 8'($urandom);
		end else if (kind < 30) begin
			// cut the tail so the end mark lands inside a sequence
			repeat ($urandom_range(1, 2))
				if (bytes.size() > 1)
					void'(bytes.pop_back());
		end
		foreach (bytes[i])
			send_byte(bytes[i], i == bytes.size() - 1);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i])
			send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);

		// rotate idle patterns every 150 counted bytes
		while (counted_bytes < RANDOM_BYTES) begin
			case ((counted_bytes / 150) % 4)
				0: begin
					send_idle_pct <= 0;
					recv_stall_pct <= 0;
				end
				1: begin
					send_idle_pct <= 54;
					recv_stall_pct <= 0;
				end
				2: begin
					send_idle_pct <= 0;
					recv_stall_pct <= 54;
				end
				default: begin
					send_idle_pct <= 12;
					recv_stall_pct <= 12;
				end
			endcase
			send_random_string();
		end
		push <= 1'b0;

		while (tracker.decoded_queue.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (tracker.mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
